>>> design/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg: shared types and constants of the biquad IIR filter
// Field widths, configuration register indexes, reset values and the
// configuration bundle that goes from the register bank to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

  localparam int COEF_W    = 32;   // Q2.29 coefficient word
  localparam int DATA_W    = 16;   // sample field and result field
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;   // widest register

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0   = 3'd0,
    REG_COEF_B1   = 3'd1,
    REG_COEF_B2   = 3'd2,
    REG_COEF_A1   = 3'd3,
    REG_COEF_A2   = 3'd4,
    REG_OVF_LIMIT = 3'd5,
    REG_OVF_SUBST = 3'd6,
    REG_UNSIGNED  = 3'd7
  } bqf_reg_e;

  localparam logic [COEF_W-1:0]  RST_COEF_B0   = 32'sd1944376;
  localparam logic [COEF_W-1:0]  RST_COEF_B1   = 32'sd3888751;
  localparam logic [COEF_W-1:0]  RST_COEF_B2   = 32'sd1944376;
  localparam logic [COEF_W-1:0]  RST_COEF_A1   = -32'sd978551887;
  localparam logic [COEF_W-1:0]  RST_COEF_A2   = 32'sd449458477;
  localparam logic [LIMIT_W-1:0] RST_OVF_LIMIT = 15'd32767;
  localparam logic [DATA_W-1:0]  RST_OVF_SUBST = 16'd450;
  localparam logic               RST_UNSIGNED  = 1'b1;

  typedef struct packed {
    logic [COEF_W-1:0]  coef_b0;
    logic [COEF_W-1:0]  coef_b1;
    logic [COEF_W-1:0]  coef_b2;
    logic [COEF_W-1:0]  coef_a1;
    logic [COEF_W-1:0]  coef_a2;
    logic [LIMIT_W-1:0] overflow_limit;
    logic [DATA_W-1:0]  overflow_substitute;
    logic               unsigned_mode;
  } bqf_cfg_t;

endpackage

`default_nettype wire

>>> design/biquad_iir_filter_top.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_top: second-order direct-form-I IIR filter
// Streaming filter with configurable Q2.29 coefficients, overflow
// substitution and signed or unsigned output clamping.
// ----------------------------------------------------------------------------
// One sample is accepted per clock cycle while the sink does not stall.
// The sample is registered, then the full biquad sum, scaling and
// clamping run in one pass into the output register. That single pass
// is what sets the throughput, since the next sample needs the previous
// result in its feedback terms. The output register holds a result
// while the sink stalls; input transfers continue while the input register
// is empty or moves into the output register in the same cycle. Write
// configuration only while no sample is in flight.
`default_nettype none

module biquad_iir_filter_top #(
  parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [bqf_pkg::DATA_W-1:0]    s_tdata,   // [15:0] sample
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [bqf_pkg::DATA_W-1:0]    m_tdata,   // [15:0] filtered
  output logic                               m_tuser,   // [0] substituted
  input  wire logic                          cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bqf_pkg::CFG_W-1:0]     cfg_data
);

  bqf_pkg::bqf_cfg_t cfg;

  logic                         in_valid;
  logic [SAMPLE_WIDTH-1:0]      in_x;
  logic [SAMPLE_WIDTH-1:0]      x1, x2;
  logic [bqf_pkg::DATA_W-1:0]   y1, y2;
  logic [bqf_pkg::DATA_W-1:0]   result;
  logic                         flag;
  logic                         out_load;
  logic                         fire;

  bqf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bqf_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .cfg         (cfg),
    .x0          (in_x),
    .x1          (x1),
    .x2          (x2),
    .y1          (y1),
    .y2          (y2),
    .result      (result),
    .substituted (flag)
  );

  assign out_load = !m_tvalid || m_tready;
  assign fire     = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      x1       <= '0;
      x2       <= '0;
      y1       <= '0;
      y2       <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_load) begin
        m_tvalid <= in_valid;
      end
      // history advances together with the result it produced
      if (fire) begin
        x1 <= in_x;
        x2 <= x1;
        y1 <= result;
        y2 <= y1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x <= s_tdata[SAMPLE_WIDTH-1:0];
    end
    if (fire) begin
      m_tdata <= result;
      m_tuser <= flag;
    end
  end

endmodule

`default_nettype wire

>>> design/bqf_cfg_regs.sv
// ----------------------------------------------------------------------------
// bqf_cfg_regs: configuration register bank
// Write-only registers for coefficients, overflow handling and output mode.
// Writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bqf_pkg::CFG_W-1:0]     cfg_data,
  output bqf_pkg::bqf_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_b0             <= bqf_pkg::RST_COEF_B0;
      cfg.coef_b1             <= bqf_pkg::RST_COEF_B1;
      cfg.coef_b2             <= bqf_pkg::RST_COEF_B2;
      cfg.coef_a1             <= bqf_pkg::RST_COEF_A1;
      cfg.coef_a2             <= bqf_pkg::RST_COEF_A2;
      cfg.overflow_limit      <= bqf_pkg::RST_OVF_LIMIT;
      cfg.overflow_substitute <= bqf_pkg::RST_OVF_SUBST;
      cfg.unsigned_mode       <= bqf_pkg::RST_UNSIGNED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqf_pkg::REG_COEF_B0:   cfg.coef_b0 <= cfg_data[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_COEF_B1:   cfg.coef_b1 <= cfg_data[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_COEF_B2:   cfg.coef_b2 <= cfg_data[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_COEF_A1:   cfg.coef_a1 <= cfg_data[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_COEF_A2:   cfg.coef_a2 <= cfg_data[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_OVF_LIMIT: cfg.overflow_limit <= cfg_data[bqf_pkg::LIMIT_W-1:0];
        bqf_pkg::REG_OVF_SUBST: cfg.overflow_substitute <= cfg_data[bqf_pkg::DATA_W-1:0];
        bqf_pkg::REG_UNSIGNED:  cfg.unsigned_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/bqf_mac.sv
// ----------------------------------------------------------------------------
// bqf_mac: biquad arithmetic for one sample
// Five products summed exactly, scaled down with truncation toward zero,
// then overflow substitution and low-end clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_mac #(
  parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire bqf_pkg::bqf_cfg_t           cfg,
  input  wire logic [SAMPLE_WIDTH-1:0]     x0,
  input  wire logic [SAMPLE_WIDTH-1:0]     x1,
  input  wire logic [SAMPLE_WIDTH-1:0]     x2,
  input  wire logic [bqf_pkg::DATA_W-1:0]  y1,
  input  wire logic [bqf_pkg::DATA_W-1:0]  y2,
  output logic      [bqf_pkg::DATA_W-1:0]  result,
  output logic                             substituted
);

  localparam int XW     = SAMPLE_WIDTH + 1;             // zero-extended sample
  localparam int PW_X   = bqf_pkg::COEF_W + XW;
  localparam int PW_Y   = bqf_pkg::COEF_W + bqf_pkg::DATA_W;
  localparam int PW_MAX = (PW_X > PW_Y) ? PW_X : PW_Y;
  localparam int ACC_W  = PW_MAX + 3;                   // room for five terms
  localparam int QW     = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);
  localparam logic [bqf_pkg::DATA_W-1:0] OUT_MIN = {1'b1, {(bqf_pkg::DATA_W-1){1'b0}}};

  logic signed [PW_X-1:0]  p_b0, p_b1, p_b2;
  logic signed [PW_Y-1:0]  p_a1, p_a2;
  logic signed [ACC_W-1:0] acc;
  logic signed [QW-1:0]    q_floor, q_trunc, q_sub;
  logic                    round_up;

  assign p_b0 = $signed(cfg.coef_b0) * $signed({1'b0, x0});
  assign p_b1 = $signed(cfg.coef_b1) * $signed({1'b0, x1});
  assign p_b2 = $signed(cfg.coef_b2) * $signed({1'b0, x2});
  assign p_a1 = $signed(cfg.coef_a1) * $signed(y1);
  assign p_a2 = $signed(cfg.coef_a2) * $signed(y2);

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // arithmetic shift floors; bump negatives with a nonzero fraction back up
  assign q_floor  = acc[ACC_W-1:COEF_FRAC_BITS];
  assign round_up = acc[ACC_W-1] & (|acc[COEF_FRAC_BITS-1:0]);
  assign q_trunc  = q_floor + $signed({{(QW-1){1'b0}}, round_up});

  assign substituted = q_trunc > $signed({{(QW-bqf_pkg::LIMIT_W){1'b0}}, cfg.overflow_limit});
  assign q_sub = substituted ? QW'($signed(cfg.overflow_substitute)) : q_trunc;

  // substitution comes first, so a negative substitute is clamped too
  always_comb begin
    if (cfg.unsigned_mode && q_sub[QW-1]) begin
      result = '0;
    end else if (q_sub < Q_MIN) begin
      result = OUT_MIN;
    end else begin
      result = q_sub[bqf_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/bqf_checker.sv
// ----------------------------------------------------------------------------
// bqf_checker: port-level checks of the biquad IIR filter
// Watches the stream ports for output holding, reset behavior, input
// readiness and the tie between input transfers and fresh results.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [bqf_pkg::DATA_W-1:0] m_tdata,
  input wire logic                       m_tuser
);

  // stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a fresh result always stems from an earlier input transfer
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a matching input transfer");

  // with the output register empty the input side never blocks
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

endmodule

bind biquad_iir_filter_top bqf_checker u_bqf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
